[design/tcfp_pkg.sv]
// Shared types and constants for the tagged command frame parser.
`default_nettype none

package tcfp_pkg;

    localparam logic [7:0] CH_START = 8'h23;  // '#'
    localparam logic [7:0] CH_END   = 8'h24;  // '$'
    localparam logic [7:0] TAG_MODE = 8'h4D;  // 'M'
    localparam logic [7:0] TAG_STEER      = 8'h53;  // 'S'
    localparam logic [7:0] TAG_STEER_RATE = 8'h57;  // 'W'
    localparam logic [7:0] TAG_SPEED      = 8'h56;  // 'V'
    localparam logic [7:0] TAG_ACCEL      = 8'h41;  // 'A'
    localparam logic [7:0] TAG_JERK       = 8'h4A;  // 'J'

    localparam int WORD_COUNT = 5;
    localparam int WORD_BYTES = 4;
    localparam int FIELD_W    = $clog2(WORD_COUNT);
    localparam int BYTE_IDX_W = $clog2(WORD_BYTES);

    localparam logic [FIELD_W-1:0] FLD_STEER      = FIELD_W'(0);
    localparam logic [FIELD_W-1:0] FLD_STEER_RATE = FIELD_W'(1);
    localparam logic [FIELD_W-1:0] FLD_SPEED      = FIELD_W'(2);
    localparam logic [FIELD_W-1:0] FLD_ACCEL      = FIELD_W'(3);
    localparam logic [FIELD_W-1:0] FLD_JERK       = FIELD_W'(4);

    localparam logic [BYTE_IDX_W-1:0] BYTE_LAST = BYTE_IDX_W'(WORD_BYTES - 1);

    localparam logic [7:0] MODE_DRIVE_A = 8'd0;
    localparam logic [7:0] MODE_DRIVE_B = 8'd1;
    localparam logic [7:0] MODE_MANUAL  = 8'd4;

    localparam logic ROUTE_DRIVE  = 1'b0;
    localparam logic ROUTE_MANUAL = 1'b1;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_TAG  = 4'b0010,
        PH_MODE = 4'b0100,
        PH_WORD = 4'b1000
    } t_phase;

    typedef struct packed {
        logic        route;
        logic [7:0]  drive_mode;
        logic [31:0] steer_word;
        logic [31:0] steer_rate_word;
        logic [31:0] speed_word;
        logic [31:0] accel_word;
        logic [31:0] jerk_word;
    } t_cmd;

endpackage

`default_nettype wire

[design/tcfp_byte_if.sv]
// Handshake channel carrying one received byte per beat.
`default_nettype none

interface tcfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[design/tcfp_cmd_if.sv]
// Handshake channel carrying one decoded command per beat.
`default_nettype none

interface tcfp_cmd_if;
    logic        valid;
    logic        ready;
    logic        route;
    logic [7:0]  drive_mode;
    logic [31:0] steer_word;
    logic [31:0] steer_rate_word;
    logic [31:0] speed_word;
    logic [31:0] accel_word;
    logic [31:0] jerk_word;

    modport source (
        output valid, output route, output drive_mode, output steer_word,
        output steer_rate_word, output speed_word, output accel_word,
        output jerk_word, input ready
    );
    modport sink (
        input valid, input route, input drive_mode, input steer_word,
        input steer_rate_word, input speed_word, input accel_word,
        input jerk_word, output ready
    );
endinterface

`default_nettype wire

[design/tcfp_parser.sv]
// Frame parser state machine with the stored mode and command words.
`default_nettype none

module tcfp_parser
    import tcfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_byte_valid,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_cmd_valid,
    output t_cmd            o_cmd
);

    t_phase                r_phase, n_phase;
    logic [FIELD_W-1:0]    r_field, n_field;
    logic [BYTE_IDX_W-1:0] r_byte_idx, n_byte_idx;
    logic [7:0]            r_mode, n_mode;
    logic [31:0]           r_word [WORD_COUNT];
    logic [31:0]           n_word [WORD_COUNT];
    logic                  mode_known;

    assign mode_known = r_mode inside {MODE_DRIVE_A, MODE_DRIVE_B, MODE_MANUAL};

    always_comb begin
        n_phase     = r_phase;
        n_field     = r_field;
        n_byte_idx  = r_byte_idx;
        n_mode      = r_mode;
        n_word      = r_word;
        o_cmd_valid = 1'b0;

        if (i_byte_valid) begin
            case (r_phase)
                PH_TAG: begin
                    n_phase = PH_WORD;
                    case (i_rx_byte)
                        TAG_MODE:       n_phase = PH_MODE;
                        TAG_STEER:      n_field = FLD_STEER;
                        TAG_STEER_RATE: n_field = FLD_STEER_RATE;
                        TAG_SPEED:      n_field = FLD_SPEED;
                        TAG_ACCEL:      n_field = FLD_ACCEL;
                        TAG_JERK:       n_field = FLD_JERK;
                        CH_END: begin
                            n_phase     = PH_HUNT;
                            o_cmd_valid = mode_known;
                        end
                        default:        n_phase = PH_HUNT;
                    endcase
                end
                PH_MODE: begin
                    n_mode  = i_rx_byte;
                    n_phase = PH_TAG;
                end
                PH_WORD: begin
                    // Payload bytes are data whatever their value, marks included.
                    n_word[r_field][r_byte_idx*8 +: 8] = i_rx_byte;
                    if (r_byte_idx == BYTE_LAST) begin
                        n_phase    = PH_TAG;
                        n_byte_idx = '0;
                    end else begin
                        n_byte_idx = r_byte_idx + 1'b1;
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == CH_START) ? PH_TAG : PH_HUNT;
                end
            endcase
        end
    end

    assign o_cmd.route           = (r_mode == MODE_MANUAL) ? ROUTE_MANUAL : ROUTE_DRIVE;
    assign o_cmd.drive_mode      = r_mode;
    assign o_cmd.steer_word      = r_word[FLD_STEER];
    assign o_cmd.steer_rate_word = r_word[FLD_STEER_RATE];
    assign o_cmd.speed_word      = r_word[FLD_SPEED];
    assign o_cmd.accel_word      = r_word[FLD_ACCEL];
    assign o_cmd.jerk_word       = r_word[FLD_JERK];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_field    <= FLD_STEER;
            r_byte_idx <= '0;
            r_mode     <= '0;
            for (int i = 0; i < WORD_COUNT; i++) begin
                r_word[i] <= '0;
            end
        end else begin
            r_phase    <= n_phase;
            r_field    <= n_field;
            r_byte_idx <= n_byte_idx;
            r_mode     <= n_mode;
            r_word     <= n_word;
        end
    end

    a_idx_only_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_WORD) |-> (r_byte_idx == '0))
        else $error("byte index left non-zero outside a word field");

    a_field_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WORD) |-> (r_field <= FLD_JERK))
        else $error("word field index out of range");

    a_emit_from_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid |=> (r_phase == PH_HUNT))
        else $error("end mark did not return the parser to hunting");

endmodule

`default_nettype wire

[design/tcfp_out_stage.sv]
// Result register with a skid entry so the parser keeps taking bytes under stall.
`default_nettype none

module tcfp_out_stage
    import tcfp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_cmd      o_cmd
);

    logic r_out_valid, n_out_valid;
    logic r_skid_valid, n_skid_valid;
    t_cmd r_out, n_out;
    t_cmd r_skid, n_skid;
    logic pop;

    assign pop     = r_out_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_cmd   = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;

        if (pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end

        if (i_cmd_valid) begin
            if (!r_out_valid || (pop && !r_skid_valid)) begin
                n_out       = i_cmd;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_cmd;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while the result register is empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid |-> o_ready)
        else $error("command pushed while the skid entry is occupied");

    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_cmd)))
        else $error("command beat changed while the receiver stalled");

endmodule

`default_nettype wire

[design/tagged_command_frame_parser.sv]
// Top level of the tagged command frame parser.
// i_rx carries one received byte per beat. Frames are '#', any number of
// tagged fields, then '$'. Tag 'M' is followed by one mode byte; tags S, W,
// V, A and J by four bytes, least significant first, that fill the steering,
// steering-rate, speed, acceleration and jerk words. An unknown tag returns
// the parser to hunting for '#'. Stored values persist across frames.
// On '$' a beat appears on o_cmd with the stored mode and the five words:
// route 0 for mode 0 or 1, route 1 for mode 4, and no beat for other modes.
// Throughput is one byte per cycle while i_rx.ready is high; each byte is one state step of the parser.
// The command beat is registered in the output stage when the '$' beat is accepted.
// The output holds a result register and one skid entry, so bytes continue
// to be taken while a command waits; i_rx.ready falls only once two
// commands are waiting, and rises again as soon as one is taken.
// Reset (synchronous, active low) returns the parser to hunting, clears the
// mode and all five words, and empties the output.
`default_nettype none

module tagged_command_frame_parser
    import tcfp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tcfp_byte_if.sink   i_rx,
    tcfp_cmd_if.source  o_cmd
);

    logic byte_accept;
    logic stage_ready;
    logic cmd_valid;
    t_cmd cmd;
    t_cmd out_cmd;

    assign i_rx.ready  = stage_ready;
    assign byte_accept = i_rx.valid && stage_ready;

    tcfp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (byte_accept),
        .i_rx_byte    (i_rx.rx_byte),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd)
    );

    tcfp_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_ready     (stage_ready),
        .o_valid     (o_cmd.valid),
        .i_ready     (o_cmd.ready),
        .o_cmd       (out_cmd)
    );

    assign o_cmd.route           = out_cmd.route;
    assign o_cmd.drive_mode      = out_cmd.drive_mode;
    assign o_cmd.steer_word      = out_cmd.steer_word;
    assign o_cmd.steer_rate_word = out_cmd.steer_rate_word;
    assign o_cmd.speed_word      = out_cmd.speed_word;
    assign o_cmd.accel_word      = out_cmd.accel_word;
    assign o_cmd.jerk_word       = out_cmd.jerk_word;

endmodule

`default_nettype wire
